>>> rtl/bolt_pkg.sv
package bolt_pkg;

    // field widths fixed by the item formats
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 5;
    localparam int LIMIT_W   = 5;

    // defaults
    localparam int CAPACITY_DEFAULT = 16;
    localparam logic [LIMIT_W-1:0] MAX_ENTRIES_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_MODIFY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_MISSING = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_SCAN,
        ST_SHIFT_DOWN,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t                        operation;
        logic signed [VALUE_W-1:0]  key;
        logic signed [VALUE_W-1:0]  new_value;
    } in_t;

    typedef struct packed {
        status_t                    status;
        logic [COUNT_W-1:0]         entry_count;
    } out_t;

endpackage

>>> rtl/bounded_ordered_list_table.sv
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_data   (operation, key, new_value)
// m_        out        m_valid / m_ready  m_data   (status, entry_count)
// cfg_      in         cfg_wr_en          cfg_wr_data (max_entries)
//
// one transaction at a time; entry memory has one registered read and one write a cycle
// an insert shifts entries up, search/modify scan, delete scans then shifts down; a full
// insert goes straight to its result; each operation passes through idle before the next
// reset (aresetn low, synchronous) empties the list and sets max_entries to 16;
// entry memory is not cleared, only entries below the count are read
// s_ready is low while an operation runs; a held result stalls only the next one's last cycle
module bounded_ordered_list_table #(
    parameter int CAPACITY = bolt_pkg::CAPACITY_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  bolt_pkg::in_t                 s_data,

    output logic                          m_valid,
    input  logic                          m_ready,
    output bolt_pkg::out_t                m_data,

    input  logic                          cfg_wr_en,
    input  logic [bolt_pkg::LIMIT_W-1:0]  cfg_wr_data
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LIM_W  = (CNT_W > bolt_pkg::LIMIT_W) ? CNT_W : bolt_pkg::LIMIT_W;
    localparam int OCW    = bolt_pkg::COUNT_W;
    localparam int VW     = bolt_pkg::VALUE_W;

    bolt_pkg::state_t              state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic                          pend_reg, pend_next;
    logic [ADDR_W-1:0]             pend_addr_reg, pend_addr_next;
    bolt_pkg::in_t                 item_reg, item_next;
    bolt_pkg::status_t             res_status_reg, res_status_next;
    logic [bolt_pkg::LIMIT_W-1:0]  max_entries_reg;
    logic                          m_valid_reg, m_valid_next;
    bolt_pkg::out_t                m_data_reg, m_data_next;

    // entry memory, one read and one write per cycle
    logic [VW-1:0]                 mem [CAPACITY];
    logic [VW-1:0]                 rd_data_reg;
    logic                          rd_en, wr_en;
    logic [ADDR_W-1:0]             rd_addr, wr_addr;
    logic [VW-1:0]                 wr_data;

    logic [LIM_W-1:0]              limit;
    logic                          is_full;
    logic                          hit;

    // effective limit is the smaller of max_entries and capacity
    always_comb begin
        if (LIM_W'(max_entries_reg) < LIM_W'(CAPACITY)) begin
            limit = LIM_W'(max_entries_reg);
        end else begin
            limit = LIM_W'(CAPACITY);
        end
    end

    assign is_full = (LIM_W'(count_reg) >= limit);
    assign hit     = pend_reg && (rd_data_reg == item_reg.key);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= bolt_pkg::MAX_ENTRIES_RESET;
        end else if (cfg_wr_en) begin
            max_entries_reg <= cfg_wr_data;
        end
    end

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bolt_pkg::ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        pend_addr_reg  <= pend_addr_next;
        item_reg       <= item_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        item_next       = item_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[ADDR_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = pend_addr_reg;
        wr_data         = rd_data_reg;
        s_ready         = 1'b0;

        // output register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            bolt_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                pend_next = 1'b0;
                if (s_valid) begin
                    item_next = s_data;
                    if (s_data.operation == bolt_pkg::OP_INSERT) begin
                        if (is_full) begin
                            res_status_next = bolt_pkg::STAT_FULL;
                            state_next      = bolt_pkg::ST_DONE;
                        end else begin
                            idx_next   = count_reg;
                            state_next = bolt_pkg::ST_SHIFT_UP;
                        end
                    end else begin
                        idx_next   = '0;
                        state_next = bolt_pkg::ST_SCAN;
                    end
                end
            end

            // move entries one place back, last first, then write the front
            bolt_pkg::ST_SHIFT_UP: begin
                if (pend_reg) begin
                    wr_en = 1'b1;
                end
                if (idx_reg != '0) begin
                    rd_en          = 1'b1;
                    rd_addr        = ADDR_W'(idx_reg - CNT_W'(1));
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[ADDR_W-1:0];
                    idx_next       = idx_reg - CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        wr_en           = 1'b1;
                        wr_addr         = '0;
                        wr_data         = item_reg.new_value;
                        count_next      = count_reg + CNT_W'(1);
                        res_status_next = bolt_pkg::STAT_OK;
                        state_next      = bolt_pkg::ST_DONE;
                    end
                end
            end

            // read ahead one entry, compare the one read last cycle
            bolt_pkg::ST_SCAN: begin
                if (hit) begin
                    pend_next       = 1'b0;
                    res_status_next = bolt_pkg::STAT_OK;
                    case (item_reg.operation)
                        bolt_pkg::OP_DELETE: begin
                            idx_next   = CNT_W'(pend_addr_reg) + CNT_W'(1);
                            state_next = bolt_pkg::ST_SHIFT_DOWN;
                        end
                        bolt_pkg::OP_MODIFY: begin
                            wr_en      = 1'b1;
                            wr_data    = item_reg.new_value;
                            state_next = bolt_pkg::ST_DONE;
                        end
                        default: begin
                            state_next = bolt_pkg::ST_DONE;
                        end
                    endcase
                end else if (idx_reg < count_reg) begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[ADDR_W-1:0];
                    idx_next       = idx_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        res_status_next = bolt_pkg::STAT_MISSING;
                        state_next      = bolt_pkg::ST_DONE;
                    end
                end
            end

            // close the gap left by the deleted entry
            bolt_pkg::ST_SHIFT_DOWN: begin
                if (pend_reg) begin
                    wr_en = 1'b1;
                end
                if (idx_reg < count_reg) begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = ADDR_W'(idx_reg - CNT_W'(1));
                    idx_next       = idx_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = bolt_pkg::ST_DONE;
                    end
                end
            end

            // hand the result to the output register once it is free
            bolt_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = res_status_reg;
                    m_data_next.entry_count = OCW'(count_reg);
                    state_next              = bolt_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = bolt_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // count never passes the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // no memory write while idle or waiting on the output
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bolt_pkg::ST_IDLE || state_reg == bolt_pkg::ST_DONE) |-> !wr_en)
        else $error("memory write outside an operation");

    // a pending read only exists while walking the list
    a_pend_state: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == bolt_pkg::ST_SHIFT_UP || state_reg == bolt_pkg::ST_SCAN
                      || state_reg == bolt_pkg::ST_SHIFT_DOWN))
        else $error("pending read outside a walk");

    // count moves only as an operation finishes
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && count_reg != $past(count_reg)) |-> state_reg == bolt_pkg::ST_DONE)
        else $error("count changed mid operation");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CAPACITY = bolt_pkg::CAPACITY_DEFAULT;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [bolt_pkg::VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [bolt_pkg::VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    bolt_pkg::in_t                s_data;
    logic                         m_valid;
    logic                         m_ready;
    bolt_pkg::out_t               m_data;
    logic                         cfg_wr_en;
    logic [bolt_pkg::LIMIT_W-1:0] cfg_wr_data;

    // shadow copy of the list and its limit
    logic [bolt_pkg::VALUE_W-1:0] list_vals [CAPACITY];
    int                           list_count = 0;
    logic [bolt_pkg::LIMIT_W-1:0] limit_reg = bolt_pkg::MAX_ENTRIES_RESET;

    // results still owed by the block, oldest first
    bolt_pkg::out_t     expected_results [$];
    bolt_pkg::out_t     head_result;
    int                 mismatch_count = 0;

    // idling and holdoff controls
    bit                 tx_idle_en = 1'b1;
    bit                 rx_idle_en = 1'b1;
    int                 holdoff_cycles = 0;
    bit                 holdoff_active = 1'b0;

    bounded_ordered_list_table #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // apply one operation to the shadow list and return its result
    function automatic bolt_pkg::out_t apply_list_op(bolt_pkg::in_t item);
        bolt_pkg::out_t res;
        int   cap_limit;
        int   pos;
        int   i;
        res.status = bolt_pkg::STAT_OK;
        cap_limit = (int'(limit_reg) < CAPACITY) ? int'(limit_reg) : CAPACITY;
        if (item.operation == bolt_pkg::OP_INSERT) begin
            if (list_count >= cap_limit) begin
                res.status = bolt_pkg::STAT_FULL;
            end else begin
                for (i = list_count; i > 0; i--) begin
                    list_vals[IDX_W'(i)] = list_vals[IDX_W'(i - 1)];
                end
                list_vals[0] = item.new_value;
                list_count++;
            end
        end else begin
            // first match from the front, full 32-bit compare
            pos = list_count;
            for (i = 0; i < list_count && pos == list_count; i++) begin
                if (list_vals[IDX_W'(i)] == item.key) pos = i;
            end
            if (pos == list_count) begin
                res.status = bolt_pkg::STAT_MISSING;
            end else if (item.operation == bolt_pkg::OP_DELETE) begin
                for (i = pos; i + 1 < list_count; i++) begin
                    list_vals[IDX_W'(i)] = list_vals[IDX_W'(i + 1)];
                end
                list_count--;
            end else if (item.operation == bolt_pkg::OP_MODIFY) begin
                list_vals[IDX_W'(pos)] = item.new_value;
            end
        end
        res.entry_count = list_count[bolt_pkg::COUNT_W-1:0];
        return res;
    endfunction

    // value mix: small numbers for duplicates, extremes, and full random
    function automatic logic [bolt_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 7));
            1: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return '1;
                    default: return '0;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // offer one transaction, record its expected result once accepted
    task automatic send_op(input bolt_pkg::op_t op, input logic [bolt_pkg::VALUE_W-1:0] key,
                           input logic [bolt_pkg::VALUE_W-1:0] nv);
        bolt_pkg::in_t item;
        item.operation = op;
        item.key = key;
        item.new_value = nv;
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(apply_list_op(item));
        // optional gap before the next transaction
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic release_sender();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_results_drained();
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // register write, only with the block idle
    task automatic write_max_entries(input logic [bolt_pkg::LIMIT_W-1:0] value);
        release_sender();
        wait_results_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        limit_reg = value;
        cfg_wr_en <= 1'b0;
    endtask

    // random operation, keys mostly taken from the current list
    task automatic send_random_op(input int insert_pct);
        bolt_pkg::op_t                op;
        logic [bolt_pkg::VALUE_W-1:0] key;
        if ($urandom_range(0, 99) < insert_pct) begin
            op = bolt_pkg::OP_INSERT;
        end else begin
            case ($urandom_range(0, 2))
                0: op = bolt_pkg::OP_SEARCH;
                1: op = bolt_pkg::OP_DELETE;
                default: op = bolt_pkg::OP_MODIFY;
            endcase
        end
        if (list_count > 0 && $urandom_range(0, 9) < 7)
            key = list_vals[IDX_W'($urandom_range(0, list_count - 1))];
        else
            key = pick_value();
        send_op(op, key, pick_value());
    endtask

    // empty list, extremes, duplicates, single-bit key miss
    task automatic test_directed_ops();
        send_op(bolt_pkg::OP_SEARCH, '0, $urandom());
        send_op(bolt_pkg::OP_DELETE, VAL_MIN, $urandom());
        send_op(bolt_pkg::OP_MODIFY, '1, $urandom());
        send_op(bolt_pkg::OP_INSERT, $urandom(), VAL_MIN);
        send_op(bolt_pkg::OP_INSERT, $urandom(), VAL_MAX);
        send_op(bolt_pkg::OP_INSERT, $urandom(), '0);
        send_op(bolt_pkg::OP_INSERT, $urandom(), '1);
        send_op(bolt_pkg::OP_INSERT, $urandom(), VAL_MAX);
        send_op(bolt_pkg::OP_SEARCH, 32'h7fff_fffe, $urandom());
        send_op(bolt_pkg::OP_SEARCH, '0, $urandom());
        send_op(bolt_pkg::OP_MODIFY, VAL_MAX, 32'd5);
        send_op(bolt_pkg::OP_SEARCH, VAL_MAX, $urandom());
        send_op(bolt_pkg::OP_DELETE, VAL_MAX, $urandom());
        send_op(bolt_pkg::OP_DELETE, VAL_MIN, $urandom());
        send_op(bolt_pkg::OP_DELETE, 32'd5, $urandom());
    endtask

    // zero limit, limit under the count, limit above capacity
    task automatic test_limit_cases();
        int i;
        write_max_entries(5'd0);
        send_op(bolt_pkg::OP_INSERT, $urandom(), 32'd9);
        write_max_entries(5'd1);
        send_op(bolt_pkg::OP_INSERT, $urandom(), 32'd9);
        send_op(bolt_pkg::OP_DELETE, '1, $urandom());
        send_op(bolt_pkg::OP_INSERT, $urandom(), 32'd9);
        send_op(bolt_pkg::OP_DELETE, '0, $urandom());
        send_op(bolt_pkg::OP_INSERT, $urandom(), 32'd7);
        send_op(bolt_pkg::OP_INSERT, $urandom(), 32'd8);
        write_max_entries(5'd31);
        for (i = 0; i < 4; i++) send_op(bolt_pkg::OP_INSERT, $urandom(), pick_value());
    endtask

    // random traffic over a range of limits and operation mixes
    task automatic test_random_mix();
        int                           phase;
        int                           n;
        int                           insert_pct;
        logic [bolt_pkg::LIMIT_W-1:0] lim;
        for (phase = 0; phase < 9; phase++) begin
            case (phase)
                0: lim = 5'd16;
                1: lim = 5'd31;
                2: lim = 5'd0;
                3: lim = 5'd1;
                4: lim = 5'd2;
                5: lim = 5'd17;
                6: lim = 5'($urandom_range(0, 31));
                7: lim = 5'd8;
                default: lim = 5'd16;
            endcase
            write_max_entries(lim);
            insert_pct = (phase % 3 == 0) ? 70 : ((phase % 3 == 1) ? 30 : 50);
            tx_idle_en = (phase % 4 != 3);
            rx_idle_en = (phase % 4 != 2);
            for (n = 0; n < 160; n++) send_random_op(insert_pct);
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering transactions
    task automatic test_output_holdoff();
        int n;
        release_sender();
        holdoff_cycles = 400;
        while (!holdoff_active) @(posedge aclk);
        tx_idle_en = 1'b0;
        for (n = 0; n < 24; n++) send_random_op(50);
        tx_idle_en = 1'b1;
    endtask

    // sender stops until every result is back, then resumes
    task automatic test_sender_pause();
        int n;
        for (n = 0; n < 20; n++) send_random_op(55);
        release_sender();
        wait_results_drained();
        for (n = 0; n < 20; n++) send_random_op(45);
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        int n;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (n = 0; n < 120; n++) send_random_op(50);
    endtask

    // receiver: random stall bursts and the requested long holdoff
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (holdoff_cycles > 0) begin
                holdoff_active = 1'b1;
                m_ready <= 1'b0;
                repeat (holdoff_cycles) @(posedge aclk);
                holdoff_cycles = 0;
                holdoff_active = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected transaction: expected none, actual status %0d count %0d",
                         $time, m_data.status, m_data.entry_count);
                mismatch_count++;
            end else begin
                head_result = expected_results.pop_front();
                if (m_data.status !== head_result.status) begin
                    $display("%0t status mismatch: expected %0d, actual %0d",
                             $time, head_result.status, m_data.status);
                    mismatch_count++;
                end
                if (m_data.entry_count !== head_result.entry_count) begin
                    $display("%0t entry_count mismatch: expected %0d, actual %0d",
                             $time, head_result.entry_count, m_data.entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    // test sequence
    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_ops();
        test_limit_cases();
        test_random_mix();
        test_output_holdoff();
        test_sender_pause();
        test_steady_stream();

        release_sender();
        wait_results_drained();
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
